// ===== rtl/core/sbcb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcb_pkg
// Shared types, codes and defaults of the separable circular-border blur.
// ----------------------------------------------------------------------------
package sbcb_pkg;

  // Default sizes
  localparam int MaxWidthDef    = 256;
  localparam int MaxHeightDef   = 256;
  localparam int MaxRadiusDef   = 4;
  localparam int TapFracBitsDef = 16;

  // Fixed field widths
  localparam int POS_W   = 8;
  localparam int PIX_W   = 8;
  localparam int TIDX_W  = 4;
  localparam int TAP_W   = 24;
  localparam int OP_W    = 2;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 2;
  localparam int CNT_W   = 3;   // holds POS_W-1 and MAX_RADIUS-1

  // Item opcodes
  localparam logic [OP_W-1:0] OP_WR_PIX  = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_VTAP = 2'd1;
  localparam logic [OP_W-1:0] OP_WR_HTAP = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_RADIUS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_WRAP,
    ST_INIT,
    ST_VREAD,
    ST_VDRAIN,
    ST_VRND,
    ST_HMAC,
    ST_HRND
  } state_e;

  typedef struct packed {
    logic wr_item;   // store a pixel or a tap
    logic start;     // capture a read position
    logic mod_step;  // one restoring step of pos mod size
    logic wrap_step; // move start position back by one, wrapping
    logic init;      // load column/row walkers, clear accumulators
    logic rd_issue;  // read one frame pixel for the vertical pass
    logic vround;    // round and clamp the column sum
    logic hmac;      // accumulate one horizontal tap, next column
    logic out_load;  // round final sum into the output register
  } cmd_t;

  typedef struct packed {
    logic mod_last;
    logic wrap_last;
    logic dy_last;
    logic dx_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/sbcb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/core/sbcb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcb_ctrl
// Sequencer: position reduction, per-column vertical pass, horizontal MAC.
// ----------------------------------------------------------------------------
module sbcb_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [sbcb_pkg::OP_W-1:0] op_i,
  output logic                      in_ready_o,
  input  sbcb_pkg::status_t         status_i,
  output sbcb_pkg::cmd_t            cmd_o
);

  sbcb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbcb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbcb_pkg::ST_IDLE: begin
        if (in_valid_i && op_i == sbcb_pkg::OP_READ) state_d = sbcb_pkg::ST_MOD;
      end
      sbcb_pkg::ST_MOD: begin
        if (status_i.mod_last) state_d = sbcb_pkg::ST_WRAP;
      end
      sbcb_pkg::ST_WRAP: begin
        if (status_i.wrap_last) state_d = sbcb_pkg::ST_INIT;
      end
      sbcb_pkg::ST_INIT:   state_d = sbcb_pkg::ST_VREAD;
      sbcb_pkg::ST_VREAD: begin
        if (status_i.dy_last) state_d = sbcb_pkg::ST_VDRAIN;
      end
      sbcb_pkg::ST_VDRAIN: state_d = sbcb_pkg::ST_VRND;
      sbcb_pkg::ST_VRND:   state_d = sbcb_pkg::ST_HMAC;
      sbcb_pkg::ST_HMAC: begin
        state_d = status_i.dx_last ? sbcb_pkg::ST_HRND : sbcb_pkg::ST_VREAD;
      end
      sbcb_pkg::ST_HRND: begin
        if (status_i.out_free) state_d = sbcb_pkg::ST_IDLE;
      end
      default: state_d = sbcb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sbcb_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.wr_item = in_valid_i && (op_i != sbcb_pkg::OP_READ);
        cmd_o.start   = in_valid_i && (op_i == sbcb_pkg::OP_READ);
      end
      sbcb_pkg::ST_MOD:    cmd_o.mod_step  = 1'b1;
      sbcb_pkg::ST_WRAP:   cmd_o.wrap_step = 1'b1;
      sbcb_pkg::ST_INIT:   cmd_o.init      = 1'b1;
      sbcb_pkg::ST_VREAD:  cmd_o.rd_issue  = 1'b1;
      sbcb_pkg::ST_VDRAIN: cmd_o           = '0;
      sbcb_pkg::ST_VRND:   cmd_o.vround    = 1'b1;
      sbcb_pkg::ST_HMAC:   cmd_o.hmac      = 1'b1;
      sbcb_pkg::ST_HRND:   cmd_o.out_load  = status_i.out_free;
      default:             cmd_o           = '0;
    endcase
  end

endmodule

// ===== rtl/core/sbcb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcb_dp
// Datapath: config and tap registers, frame RAM, wrap walkers, shared MAC.
// ----------------------------------------------------------------------------
module sbcb_dp #(
  parameter int MAX_WIDTH     = sbcb_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT    = sbcb_pkg::MaxHeightDef,
  parameter int MAX_RADIUS    = sbcb_pkg::MaxRadiusDef,
  parameter int TAP_FRAC_BITS = sbcb_pkg::TapFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sbcb_pkg::cmd_t                cmd_i,
  output sbcb_pkg::status_t             status_o,
  input  logic [sbcb_pkg::OP_W-1:0]     op_i,
  input  logic [sbcb_pkg::POS_W-1:0]    pos_x_i,
  input  logic [sbcb_pkg::POS_W-1:0]    pos_y_i,
  input  logic [sbcb_pkg::PIX_W-1:0]    pixel_in_i,
  input  logic [sbcb_pkg::TIDX_W-1:0]   tap_index_i,
  input  logic [sbcb_pkg::TAP_W-1:0]    tap_value_i,
  input  logic                          cfg_we_i,
  input  logic [sbcb_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [sbcb_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sbcb_pkg::PIX_W-1:0]    pixel_out_o
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int SXW    = XW + 1;
  localparam int SYW    = YW + 1;
  localparam int CXW    = (SXW > sbcb_pkg::CFG_W) ? SXW : sbcb_pkg::CFG_W;
  localparam int CYW    = (SYW > sbcb_pkg::CFG_W) ? SYW : sbcb_pkg::CFG_W;
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int NTAP   = 2 * MAX_RADIUS + 1;
  localparam int TIW    = $clog2(NTAP);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int PRODW  = sbcb_pkg::PIX_W + sbcb_pkg::TAP_W;
  localparam int ACCW   = PRODW + $clog2(NTAP) + 1;
  localparam int PW     = sbcb_pkg::POS_W;

  // ---------------- configuration ----------------
  logic [sbcb_pkg::CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [2:0]                 cfg_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= sbcb_pkg::CFG_W'(256);
      cfg_h_q <= sbcb_pkg::CFG_W'(256);
      cfg_r_q <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbcb_pkg::CFG_WIDTH:  cfg_w_q <= cfg_data_i;
        sbcb_pkg::CFG_HEIGHT: cfg_h_q <= cfg_data_i;
        sbcb_pkg::CFG_RADIUS: cfg_r_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [CXW-1:0] wx;
  logic [CYW-1:0] hx;
  logic [4:0]     rx;
  logic [SXW-1:0] w_eff;
  logic [SYW-1:0] h_eff;
  logic [RW-1:0]  r_eff;

  // zero acts as one, oversize saturates
  always_comb begin
    wx = CXW'(cfg_w_q);
    hx = CYW'(cfg_h_q);
    rx = 5'(cfg_r_q);
    if (wx == '0) wx = CXW'(1);
    else if (wx > CXW'(MAX_WIDTH)) wx = CXW'(MAX_WIDTH);
    if (hx == '0) hx = CYW'(1);
    else if (hx > CYW'(MAX_HEIGHT)) hx = CYW'(MAX_HEIGHT);
    if (rx == '0) rx = 5'd1;
    else if (rx > 5'(MAX_RADIUS)) rx = 5'(MAX_RADIUS);
    w_eff = SXW'(wx);
    h_eff = SYW'(hx);
    r_eff = RW'(rx);
  end

  logic [TIW-1:0] two_r;
  assign two_r = TIW'({r_eff, 1'b0});

  // ---------------- tap registers ----------------
  logic [sbcb_pkg::TAP_W-1:0] vtap_q [NTAP];
  logic [sbcb_pkg::TAP_W-1:0] htap_q [NTAP];
  logic                       tap_ok;
  logic [TIW-1:0]             tap_wi;

  assign tap_ok = 6'(tap_index_i) < 6'(NTAP);
  assign tap_wi = TIW'(tap_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NTAP; i++) begin
        vtap_q[i] <= '0;
        htap_q[i] <= '0;
      end
    end else if (cmd_i.wr_item && tap_ok) begin
      if (op_i == sbcb_pkg::OP_WR_VTAP) vtap_q[tap_wi] <= tap_value_i;
      if (op_i == sbcb_pkg::OP_WR_HTAP) htap_q[tap_wi] <= tap_value_i;
    end
  end

  // ---------------- position reduction and wrap ----------------
  logic [PW-1:0]    xs_q, ys_q;
  logic [SXW-1:0]   rem_x_q;
  logic [SYW-1:0]   rem_y_q;
  logic [sbcb_pkg::CNT_W-1:0] cnt_q;
  logic [SXW:0]     shx;
  logic [SYW:0]     shy;
  logic             wrap_last;

  assign shx = {rem_x_q, xs_q[PW-1]};
  assign shy = {rem_y_q, ys_q[PW-1]};
  assign wrap_last = ({1'b0, cnt_q} == (4'(r_eff) - 4'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.wrap_step) begin
      cnt_q <= wrap_last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      xs_q    <= pos_x_i;
      ys_q    <= pos_y_i;
      rem_x_q <= '0;
      rem_y_q <= '0;
    end else if (cmd_i.mod_step) begin
      // restoring remainder, one position bit per step
      xs_q    <= xs_q << 1;
      ys_q    <= ys_q << 1;
      rem_x_q <= (shx >= (SXW + 1)'(w_eff)) ? SXW'(shx - (SXW + 1)'(w_eff)) : SXW'(shx);
      rem_y_q <= (shy >= (SYW + 1)'(h_eff)) ? SYW'(shy - (SYW + 1)'(h_eff)) : SYW'(shy);
    end else if (cmd_i.wrap_step) begin
      rem_x_q <= (rem_x_q == '0) ? w_eff - 1'b1 : rem_x_q - 1'b1;
      rem_y_q <= (rem_y_q == '0) ? h_eff - 1'b1 : rem_y_q - 1'b1;
    end
  end

  // ---------------- window walkers ----------------
  logic [XW-1:0]  col_q;
  logic [YW-1:0]  row_q;
  logic [TIW-1:0] dx_q, dy_q, tsel_q;
  logic           mac_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_v_q <= 1'b0;
    end else begin
      mac_v_q <= cmd_i.rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    tsel_q <= dy_q;
    if (cmd_i.init) begin
      col_q <= XW'(rem_x_q);
      dx_q  <= '0;
    end else if (cmd_i.hmac) begin
      col_q <= ({1'b0, col_q} == w_eff - 1'b1) ? '0 : col_q + 1'b1;
      dx_q  <= dx_q + 1'b1;
    end
    if (cmd_i.init || cmd_i.hmac) begin
      row_q <= YW'(rem_y_q);
      dy_q  <= '0;
    end else if (cmd_i.rd_issue) begin
      row_q <= ({1'b0, row_q} == h_eff - 1'b1) ? '0 : row_q + 1'b1;
      dy_q  <= dy_q + 1'b1;
    end
  end

  // ---------------- frame memory ----------------
  logic [AW-1:0]             ram_addr;
  logic                      ram_we;
  logic [sbcb_pkg::PIX_W-1:0] ram_rdata;
  logic                      pix_ok;

  assign pix_ok = (32'(pos_x_i) < MAX_WIDTH) && (32'(pos_y_i) < MAX_HEIGHT);
  assign ram_we = cmd_i.wr_item && (op_i == sbcb_pkg::OP_WR_PIX) && pix_ok;

  always_comb begin
    if (cmd_i.wr_item) begin
      ram_addr = AW'(AW'(YW'(pos_y_i)) * AW'(MAX_WIDTH)) + AW'(XW'(pos_x_i));
    end else begin
      ram_addr = AW'(AW'(row_q) * AW'(MAX_WIDTH)) + AW'(col_q);
    end
  end

  sbcb_ram #(
    .WIDTH(sbcb_pkg::PIX_W),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(pixel_in_i),
    .rdata_o(ram_rdata)
  );

  // ---------------- shared multiplier and accumulators ----------------
  logic [sbcb_pkg::PIX_W-1:0] mul_a;
  logic [sbcb_pkg::TAP_W-1:0] mul_b;
  logic [PRODW-1:0]           prod;
  logic [ACCW-1:0]            vacc_q, hacc_q;
  logic [sbcb_pkg::PIX_W-1:0] vpix_q;

  assign mul_a = cmd_i.hmac ? vpix_q : ram_rdata;
  assign mul_b = cmd_i.hmac ? htap_q[dx_q] : vtap_q[tsel_q];
  assign prod  = PRODW'(mul_a) * PRODW'(mul_b);

  function automatic logic [sbcb_pkg::PIX_W-1:0] round_clamp(input logic [ACCW-1:0] acc);
    logic [ACCW:0] sum;
    logic [ACCW:0] shr;
    sum = (ACCW + 1)'(acc) + ((ACCW + 1)'(1) << (TAP_FRAC_BITS - 1));
    shr = sum >> TAP_FRAC_BITS;
    if (|shr[ACCW:sbcb_pkg::PIX_W]) return '1;
    return shr[sbcb_pkg::PIX_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.init || cmd_i.hmac) begin
      vacc_q <= '0;
    end else if (mac_v_q) begin
      vacc_q <= vacc_q + ACCW'(prod);
    end
    if (cmd_i.init) begin
      hacc_q <= '0;
    end else if (cmd_i.hmac) begin
      hacc_q <= hacc_q + ACCW'(prod);
    end
    if (cmd_i.vround) begin
      vpix_q <= round_clamp(vacc_q);
    end
  end

  // ---------------- output register ----------------
  logic                       out_valid_q;
  logic [sbcb_pkg::PIX_W-1:0] out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pix_q <= round_clamp(hacc_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;

  assign status_o.mod_last  = (cnt_q == '1);
  assign status_o.wrap_last = wrap_last;
  assign status_o.dy_last   = (dy_q == two_r);
  assign status_o.dx_last   = (dx_q == two_r);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/core/separable_blur_circular_border_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_blur_circular_border_unit
// Separable grayscale blur with wraparound borders over one stored frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready) carries write and read beats. Pixel and tap
//   writes return nothing. A read beat (op read) yields one beat on the
//   output channel with the filtered pixel at (x, y).
//   Config port: cfg_we_i, cfg_idx_i and cfg_data_i write width, height or
//   radius, one register per write; write only while the block is idle.
// Read sequence:
//   A read keeps the block busy, r being the effective radius: restoring
//   position reduction, r wrap steps, then for each of the 2r+1 columns one
//   frame RAM read per cycle over 2r+1 rows through the single RAM port,
//   a drain, rounding and a horizontal MAC; last, the output rounding.
//   Writes run at one beat per cycle while the block is idle.
// Reset:
//   Taps clear to zero, registers go to 256, 256 and 1. The frame memory
//   is not cleared; read only pixels that have been written.
// Stall:
//   A finished result waits in the output register; the next beat is still
//   accepted, and a later read holds at its end until that register frees.
// ----------------------------------------------------------------------------
module separable_blur_circular_border_unit #(
  parameter int MAX_WIDTH     = sbcb_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT    = sbcb_pkg::MaxHeightDef,
  parameter int MAX_RADIUS    = sbcb_pkg::MaxRadiusDef,
  parameter int TAP_FRAC_BITS = sbcb_pkg::TapFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sbcb_pkg::OP_W-1:0]     op_i,
  input  logic [sbcb_pkg::POS_W-1:0]    pos_x_i,
  input  logic [sbcb_pkg::POS_W-1:0]    pos_y_i,
  input  logic [sbcb_pkg::PIX_W-1:0]    pixel_in_i,
  input  logic [sbcb_pkg::TIDX_W-1:0]   tap_index_i,
  input  logic [sbcb_pkg::TAP_W-1:0]    tap_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sbcb_pkg::PIX_W-1:0]    pixel_out_o,
  input  logic                          cfg_we_i,
  input  logic [sbcb_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [sbcb_pkg::CFG_W-1:0]    cfg_data_i
);

  sbcb_pkg::cmd_t    cmd;
  sbcb_pkg::status_t status;

  sbcb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .op_i      (op_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sbcb_dp #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_RADIUS   (MAX_RADIUS),
    .TAP_FRAC_BITS(TAP_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .op_i       (op_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pixel_in_i (pixel_in_i),
    .tap_index_i(tap_index_i),
    .tap_value_i(tap_value_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o)
  );

endmodule

// ===== rtl/core/sbcb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcb_checker
// Port-level checks of the blur unit, bound to the top level.
// ----------------------------------------------------------------------------
module sbcb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [sbcb_pkg::OP_W-1:0]     op_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [sbcb_pkg::PIX_W-1:0]    pixel_out_o
);

  logic rd_beat, wr_beat;
  assign rd_beat = in_valid_i && in_ready_o && (op_i == sbcb_pkg::OP_READ);
  assign wr_beat = in_valid_i && in_ready_o && (op_i != sbcb_pkg::OP_READ);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o))
    else $error("output beat changed while stalled");

  // a read keeps the block busy
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_beat |=> !in_ready_o)
    else $error("input accepted right after a read beat");

  // writes never make a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_beat && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a write beat");

  // output register is cleared asynchronously while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind separable_blur_circular_border_unit sbcb_checker u_sbcb_checker (.*);

// ===== bench/tb_separable_blur_circular_border_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_separable_blur_circular_border_unit
// Self-checking bench for the separable wraparound blur. A directed table of
// beats covers reset taps, identity and saturating kernels, half-up rounding
// and ignored tap indexes. Randomized phases follow, each with its own frame
// size and radius, fresh taps, and a mix of reads and writes. Every read
// first loads any pixel of its neighborhood not yet written. Results are
// scored against a bench-side blur model in acceptance order.
// ----------------------------------------------------------------------------
module tb_separable_blur_circular_border_unit;
  import sbcb_pkg::*;

  localparam int FRAME_DIM    = 256;
  localparam int TAP_SLOTS    = 2 * MaxRadiusDef + 1;
  localparam int DRAIN_CYCLES = 160;      // outlasts the longest read
  localparam int CYCLE_LIMIT  = 3000000;

  // index 3 is not a register; writes to it must be harmless
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [PIX_W-1:0]  pix;
    logic [TIDX_W-1:0] ti;
    logic [TAP_W-1:0]  tv;
    logic              fixed;
    logic [PIX_W-1:0]  want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op_d = '0;
  logic [POS_W-1:0]  pos_x = '0;
  logic [POS_W-1:0]  pos_y = '0;
  logic [PIX_W-1:0]  pix_d = '0;
  logic [TIDX_W-1:0] tap_idx = '0;
  logic [TAP_W-1:0]  tap_val = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PIX_W-1:0]  pixel_out;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  // bench copy of the block state
  bit [PIX_W-1:0] frame_mem [FRAME_DIM*FRAME_DIM];
  bit             frame_set [FRAME_DIM*FRAME_DIM];
  bit [TAP_W-1:0] vtaps [TAP_SLOTS];
  bit [TAP_W-1:0] htaps [TAP_SLOTS];
  bit [CFG_W-1:0] width_reg = 9'd256;
  bit [CFG_W-1:0] height_reg = 9'd256;
  bit [2:0]       radius_reg = 3'd1;

  bit [PIX_W-1:0] pending_pixels [$];
  dir_row_t       dir_rows [$];
  int             err_count = 0;
  bit             idle_on = 1'b1;
  int unsigned    cycle_count = 0;

  separable_blur_circular_border_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op_d),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pixel_in_i  (pix_d),
    .tap_index_i (tap_idx),
    .tap_value_i (tap_val),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pixel_out_o (pixel_out),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------- model

  // zero acts as one, anything above the maximum saturates
  function automatic int unsigned sat_size(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic bit [PIX_W-1:0] round_sat(bit [63:0] acc);
    bit [63:0] q;
    q = (acc + (64'd1 << (TapFracBitsDef - 1))) >> TapFracBitsDef;
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  function automatic int unsigned wrap_at(int unsigned p, int unsigned d, int unsigned r,
                                          int unsigned size);
    return (p + d + size * r - r) % size;
  endfunction

  // vertical pass per column, round/clamp, then horizontal pass
  function automatic bit [PIX_W-1:0] blur_pixel(bit [POS_W-1:0] x, bit [POS_W-1:0] y);
    int unsigned w, h, r, xc, yc, col, row;
    bit [63:0]   vsum, hsum;
    w = sat_size(width_reg, FRAME_DIM);
    h = sat_size(height_reg, FRAME_DIM);
    r = sat_size(radius_reg, MaxRadiusDef);
    xc = x % w;
    yc = y % h;
    hsum = 0;
    for (int dx = 0; dx <= 2 * r; dx++) begin
      col = wrap_at(xc, dx, r, w);
      vsum = 0;
      for (int dy = 0; dy <= 2 * r; dy++) begin
        row = wrap_at(yc, dy, r, h);
        vsum += 64'(frame_mem[row*FRAME_DIM+col]) * 64'(vtaps[dy]);
      end
      hsum += 64'(round_sat(vsum)) * 64'(htaps[dx]);
    end
    return round_sat(hsum);
  endfunction

  function automatic bit [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mode below 7: taps roughly summing to one over the kernel
  function automatic bit [TAP_W-1:0] pick_tap(int unsigned mode, int unsigned r);
    if (mode < 7) return 24'($urandom_range(0, 131072 / (2 * r + 1)));
    if (mode == 7) return 24'($urandom);
    if (mode == 8) return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
    return 24'($urandom_range(0, 24'h00FFFF));
  endfunction

  // ---------------------------------------------------------------- driving

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(logic [OP_W-1:0] op, bit [POS_W-1:0] x, bit [POS_W-1:0] y,
                           bit [PIX_W-1:0] pix, bit [TIDX_W-1:0] ti, bit [TAP_W-1:0] tv,
                           bit fixed, bit [PIX_W-1:0] want);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op_d     = op;
    pos_x    = x;
    pos_y    = y;
    pix_d    = pix;
    tap_idx  = ti;
    tap_val  = tv;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (op)
      OP_WR_PIX: begin
        frame_mem[y*FRAME_DIM+x] = pix;
        frame_set[y*FRAME_DIM+x] = 1'b1;
      end
      OP_WR_VTAP: if (ti < TAP_SLOTS) vtaps[ti] = tv;
      OP_WR_HTAP: if (ti < TAP_SLOTS) htaps[ti] = tv;
      default:    pending_pixels.push_back(fixed ? want : blur_pixel(x, y));
    endcase
    @(negedge clk);
  endtask

  // loads unwritten neighbors first so no read touches an undefined pixel
  task automatic read_pixel(bit [POS_W-1:0] x, bit [POS_W-1:0] y, bit fixed,
                            bit [PIX_W-1:0] want);
    int unsigned w, h, r, xc, yc, col, row;
    w = sat_size(width_reg, FRAME_DIM);
    h = sat_size(height_reg, FRAME_DIM);
    r = sat_size(radius_reg, MaxRadiusDef);
    xc = x % w;
    yc = y % h;
    for (int dx = 0; dx <= 2 * r; dx++) begin
      col = wrap_at(xc, dx, r, w);
      for (int dy = 0; dy <= 2 * r; dy++) begin
        row = wrap_at(yc, dy, r, h);
        if (!frame_set[row*FRAME_DIM+col]) begin
          send_beat(OP_WR_PIX, 8'(col), 8'(row), pick_pixel(), 4'($urandom),
                    24'($urandom), 1'b0, 8'd0);
        end
      end
    end
    send_beat(OP_READ, x, y, 8'($urandom), 4'($urandom), 24'($urandom), fixed, want);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, bit [CFG_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_WIDTH:  width_reg = data;
      CFG_HEIGHT: height_reg = data;
      CFG_RADIUS: radius_reg = data[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(bit [CFG_W-1:0] w_data, bit [CFG_W-1:0] h_data,
                           bit [CFG_W-1:0] r_data, int n_items);
    int unsigned    w, h, r, cx, cy, tap_mode, pick;
    bit             big;
    bit [POS_W-1:0] x, y;
    bit [TIDX_W-1:0] ti;
    wait_idle();
    write_reg(CFG_SPARE, 9'($urandom));
    write_reg(CFG_WIDTH, w_data);
    write_reg(CFG_HEIGHT, h_data);
    write_reg(CFG_RADIUS, r_data);
    w = sat_size(width_reg, FRAME_DIM);
    h = sat_size(height_reg, FRAME_DIM);
    r = sat_size(radius_reg, MaxRadiusDef);
    // large frames: keep reads in one small window so few pixels need loading
    big = (w * h > 4096);
    cx = $urandom_range(0, 255);
    cy = $urandom_range(0, 255);
    idle_on = ($urandom_range(0, 3) != 0);
    tap_mode = $urandom_range(0, 9);
    for (int i = 0; i < TAP_SLOTS; i++) begin
      send_beat(OP_WR_VTAP, 8'($urandom), 8'($urandom), 8'($urandom), 4'(i),
                pick_tap(tap_mode, r), 1'b0, 8'd0);
      send_beat(OP_WR_HTAP, 8'($urandom), 8'($urandom), 8'($urandom), 4'(i),
                pick_tap(tap_mode, r), 1'b0, 8'd0);
    end
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if (big) begin
          x = 8'(cx + $urandom_range(0, 7));
          y = 8'(cy + $urandom_range(0, 7));
        end else if (pick < 6) begin
          x = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
          y = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        end else begin
          x = 8'($urandom);
          y = 8'($urandom);
        end
        read_pixel(x, y, 1'b0, 8'd0);
      end else if (pick < 80) begin
        if (pick < 72) begin
          x = 8'($urandom_range(0, w - 1));
          y = 8'($urandom_range(0, h - 1));
        end else begin
          x = 8'($urandom);
          y = 8'($urandom);
        end
        send_beat(OP_WR_PIX, x, y, pick_pixel(), 4'($urandom), 24'($urandom), 1'b0, 8'd0);
      end else begin
        ti = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2 * r));
        send_beat((pick < 90) ? OP_WR_VTAP : OP_WR_HTAP, 8'($urandom), 8'($urandom),
                  8'($urandom), ti, pick_tap(($urandom_range(0, 4) == 0) ? 7 : 0, r),
                  1'b0, 8'd0);
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    bit [CFG_W-1:0] w_data, h_data;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset config: 256 x 256, radius 1, all taps zero
    dir_rows.push_back('{OP_READ,    8'd0,   8'd0,   8'd0,   4'd0,  24'h000000, 1'b1, 8'd0});
    dir_rows.push_back('{OP_READ,    8'd255, 8'd255, 8'd0,   4'd0,  24'h000000, 1'b1, 8'd0});
    // identity kernel
    dir_rows.push_back('{OP_WR_VTAP, 8'd0,   8'd0,   8'd0,   4'd1,  24'h010000, 1'b0, 8'd0});
    dir_rows.push_back('{OP_WR_HTAP, 8'd0,   8'd0,   8'd0,   4'd1,  24'h010000, 1'b0, 8'd0});
    dir_rows.push_back('{OP_WR_PIX,  8'd0,   8'd0,   8'd255, 4'd0,  24'h000000, 1'b0, 8'd0});
    dir_rows.push_back('{OP_READ,    8'd0,   8'd0,   8'd0,   4'd0,  24'h000000, 1'b1, 8'd255});
    dir_rows.push_back('{OP_WR_PIX,  8'd255, 8'd255, 8'd0,   4'd0,  24'h000000, 1'b0, 8'd0});
    dir_rows.push_back('{OP_READ,    8'd255, 8'd255, 8'd0,   4'd0,  24'h000000, 1'b1, 8'd0});
    dir_rows.push_back('{OP_WR_PIX,  8'd128, 8'd77,  8'h5A,  4'd0,  24'h000000, 1'b0, 8'd0});
    dir_rows.push_back('{OP_READ,    8'd128, 8'd77,  8'd0,   4'd0,  24'h000000, 1'b1, 8'h5A});
    // out-of-range tap indexes must not land anywhere
    dir_rows.push_back('{OP_WR_VTAP, 8'd0,   8'd0,   8'd0,   4'd9,  24'hFFFFFF, 1'b0, 8'd0});
    dir_rows.push_back('{OP_WR_HTAP, 8'd0,   8'd0,   8'd0,   4'd15, 24'hFFFFFF, 1'b0, 8'd0});
    dir_rows.push_back('{OP_READ,    8'd128, 8'd77,  8'd0,   4'd0,  24'h000000, 1'b1, 8'h5A});
    // center tap of one half: 0.5 and 1.5 both round up
    dir_rows.push_back('{OP_WR_VTAP, 8'd0,   8'd0,   8'd0,   4'd1,  24'h008000, 1'b0, 8'd0});
    dir_rows.push_back('{OP_WR_PIX,  8'd10,  8'd10,  8'd1,   4'd0,  24'h000000, 1'b0, 8'd0});
    dir_rows.push_back('{OP_READ,    8'd10,  8'd10,  8'd0,   4'd0,  24'h000000, 1'b1, 8'd1});
    dir_rows.push_back('{OP_WR_PIX,  8'd10,  8'd10,  8'd3,   4'd0,  24'h000000, 1'b0, 8'd0});
    dir_rows.push_back('{OP_READ,    8'd10,  8'd10,  8'd0,   4'd0,  24'h000000, 1'b1, 8'd2});
    // saturating taps: both passes clamp
    dir_rows.push_back('{OP_WR_VTAP, 8'd0,   8'd0,   8'd0,   4'd0,  24'hFFFFFF, 1'b0, 8'd0});
    dir_rows.push_back('{OP_WR_VTAP, 8'd0,   8'd0,   8'd0,   4'd1,  24'hFFFFFF, 1'b0, 8'd0});
    dir_rows.push_back('{OP_WR_VTAP, 8'd0,   8'd0,   8'd0,   4'd2,  24'hFFFFFF, 1'b0, 8'd0});
    dir_rows.push_back('{OP_WR_HTAP, 8'd0,   8'd0,   8'd0,   4'd0,  24'hFFFFFF, 1'b0, 8'd0});
    dir_rows.push_back('{OP_WR_HTAP, 8'd0,   8'd0,   8'd0,   4'd2,  24'hFFFFFF, 1'b0, 8'd0});
    dir_rows.push_back('{OP_READ,    8'd0,   8'd0,   8'd0,   4'd0,  24'h000000, 1'b1, 8'd255});
    // wraps across both borders
    dir_rows.push_back('{OP_READ,    8'd255, 8'd0,   8'd0,   4'd0,  24'h000000, 1'b0, 8'd0});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == OP_READ) begin
        read_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fixed, dir_rows[i].want);
      end else begin
        send_beat(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].pix,
                  dir_rows[i].ti, dir_rows[i].tv, 1'b0, 8'd0);
      end
    end

    run_phase(9'd8,   9'd8,   9'd1, 150);
    run_phase(9'd1,   9'd1,   9'd4, 80);
    run_phase(9'd0,   9'd0,   9'd0, 80);
    run_phase(9'd511, 9'd511, 9'd7, 70);
    run_phase(9'd5,   9'd3,   9'd2, 200);
    run_phase(9'd256, 9'd1,   9'd3, 120);
    run_phase(9'd2,   9'd256, 9'd4, 120);
    run_phase(9'd256, 9'd256, 9'd1, 60);
    for (int p = 0; p < 6; p++) begin
      w_data = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(1, 24));
      h_data = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(1, 24));
      run_phase(w_data, h_data, 9'($urandom), 200);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------- scoring

  initial begin : result_check
    int             gap;
    bit [PIX_W-1:0] want;
    @(posedge rst_n);
    forever begin
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_pixels.size() == 0) begin
        $display("%0t: result beat with nothing pending: expected none, actual %0d",
                 $time, pixel_out);
        err_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out !== want) begin
          $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                   $time, want, pixel_out);
          err_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule
